FILE: design/port_pool_allocator_assert.svh
// ----------------------------------------------------------------------------
// port_pool_allocator assertion macros
// Shorthand for clocked assertions on the allocator ports, sampled on clk
// and switched off while rst is high.
// ----------------------------------------------------------------------------
`ifndef PORT_POOL_ALLOCATOR_ASSERT_SVH
`define PORT_POOL_ALLOCATOR_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define PPA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("port_pool_allocator: assertion failed");

// consequent checked in the cycle after the antecedent
`define PPA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("port_pool_allocator: assertion failed");

`endif

FILE: design/ppa_pkg.sv
// ----------------------------------------------------------------------------
// ppa_pkg
// Shared widths, marks, command and outcome codes, and the control and
// status bundles between the allocator controller and datapath.
// ----------------------------------------------------------------------------
package ppa_pkg;

  localparam int NUM_W        = 10;
  localparam int NUMBER_SPACE = 2 ** NUM_W;
  localparam int CNT_W        = 32;
  localparam int STATUS_W     = 32;
  localparam int CMD_W        = 2;
  localparam int RES_W        = 2;
  localparam int CFG_IDX_W    = 1;
  localparam int TDATA_W      = 16;

  localparam logic [STATUS_W-1:0] MARK_TAKEN        = {STATUS_W{1'b1}};
  localparam logic [STATUS_W-1:0] MARK_OUT_OF_RANGE = {{(STATUS_W-1){1'b1}}, 1'b0};

  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_FIRST = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LAST  = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT    = 2'd0,
    CMD_ALLOC   = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  typedef enum logic [RES_W-1:0] {
    OUT_OK        = 2'd0,
    OUT_EMPTY     = 2'd1,
    OUT_CORRUPT   = 2'd2,
    OUT_BAD_RANGE = 2'd3
  } outcome_t;

  // controller -> datapath
  typedef struct packed {
    logic     latch_in;
    logic     latch_cand;
    logic     stat_rd_rel;
    logic     head_inc;
    logic     fill_clear;
    logic     fill_step;
    logic     init_load;
    logic     take_write;
    logic     rel_write;
    logic     res_load;
    outcome_t res_code;
    logic     res_use_cand;
    logic     out_load;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic ring_bad;
    logic skip;
    logic range_bad;
    logic rel_ok;
    logic rel_taken;
    logic fill_last;
    logic out_free;
  } sts_t;

endpackage

FILE: design/ppa_ram.sv
// ----------------------------------------------------------------------------
// ppa_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module ppa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/ppa_ctrl.sv
// ----------------------------------------------------------------------------
// ppa_ctrl
// Sequencer for init sweep, allocate probe loop and release, one command
// at a time.
// ----------------------------------------------------------------------------
module ppa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  ppa_pkg::cmd_t in_cmd,
  output logic          in_ready,
  input  ppa_pkg::sts_t sts,
  output ppa_pkg::ctl_t ctl
);

  typedef enum logic [8:0] {
    ST_IDLE       = 9'b000000001,
    ST_INIT_CHK   = 9'b000000010,
    ST_INIT_FILL  = 9'b000000100,
    ST_ALLOC_CHK  = 9'b000001000,
    ST_ALLOC_RING = 9'b000010000,
    ST_ALLOC_EVAL = 9'b000100000,
    ST_REL_CHK    = 9'b001000000,
    ST_REL_EVAL   = 9'b010000000,
    ST_DONE       = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          ctl.latch_in = 1'b1;
          case (in_cmd)
            ppa_pkg::CMD_INIT:    state_next = ST_INIT_CHK;
            ppa_pkg::CMD_ALLOC:   state_next = ST_ALLOC_CHK;
            ppa_pkg::CMD_RELEASE: state_next = ST_REL_CHK;
            default: begin
              ctl.res_load = 1'b1;
              ctl.res_code = ppa_pkg::OUT_OK;
              state_next   = ST_DONE;
            end
          endcase
        end
      end
      ST_INIT_CHK: begin
        if (sts.range_bad) begin
          ctl.res_load = 1'b1;
          ctl.res_code = ppa_pkg::OUT_BAD_RANGE;
          state_next   = ST_DONE;
        end else begin
          ctl.fill_clear = 1'b1;
          state_next     = ST_INIT_FILL;
        end
      end
      ST_INIT_FILL: begin
        ctl.fill_step = 1'b1;
        if (sts.fill_last) begin
          ctl.init_load = 1'b1;
          ctl.res_load  = 1'b1;
          ctl.res_code  = ppa_pkg::OUT_OK;
          state_next    = ST_DONE;
        end
      end
      ST_ALLOC_CHK: begin
        // ring read at the head is issued in this cycle
        if (sts.empty) begin
          ctl.res_load = 1'b1;
          ctl.res_code = ppa_pkg::OUT_EMPTY;
          state_next   = ST_DONE;
        end else begin
          state_next = ST_ALLOC_RING;
        end
      end
      ST_ALLOC_RING: begin
        if (sts.ring_bad) begin
          ctl.res_load = 1'b1;
          ctl.res_code = ppa_pkg::OUT_CORRUPT;
          state_next   = ST_DONE;
        end else begin
          ctl.latch_cand = 1'b1;
          state_next     = ST_ALLOC_EVAL;
        end
      end
      ST_ALLOC_EVAL: begin
        ctl.head_inc = 1'b1;
        if (sts.skip) begin
          state_next = ST_ALLOC_CHK;
        end else begin
          ctl.take_write   = 1'b1;
          ctl.res_load     = 1'b1;
          ctl.res_code     = ppa_pkg::OUT_OK;
          ctl.res_use_cand = 1'b1;
          state_next       = ST_DONE;
        end
      end
      ST_REL_CHK: begin
        if (sts.rel_ok) begin
          ctl.stat_rd_rel = 1'b1;
          state_next      = ST_REL_EVAL;
        end else begin
          ctl.res_load = 1'b1;
          ctl.res_code = ppa_pkg::OUT_OK;
          state_next   = ST_DONE;
        end
      end
      ST_REL_EVAL: begin
        ctl.rel_write = sts.rel_taken;
        ctl.res_load  = 1'b1;
        ctl.res_code  = ppa_pkg::OUT_OK;
        state_next    = ST_DONE;
      end
      ST_DONE: begin
        // hold the result until the output register is free
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: design/ppa_dp.sv
// ----------------------------------------------------------------------------
// ppa_dp
// Allocator datapath: range registers, head and tail counters, free ring
// and status memories, init sweep counter, result and output registers.
// ----------------------------------------------------------------------------
module ppa_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ppa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppa_pkg::NUM_W-1:0]      cfg_data,
  input  logic [ppa_pkg::NUM_W-1:0]      in_number,
  input  ppa_pkg::ctl_t                  ctl,
  output ppa_pkg::sts_t                  sts,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [ppa_pkg::NUM_W-1:0]      out_number,
  output ppa_pkg::outcome_t              out_outcome
);

  logic [ppa_pkg::NUM_W-1:0]    range_first;
  logic [ppa_pkg::NUM_W-1:0]    range_last;
  logic [ppa_pkg::CNT_W-1:0]    head;
  logic [ppa_pkg::CNT_W-1:0]    tail;
  logic [ppa_pkg::NUM_W-1:0]    num_in;
  logic [ppa_pkg::NUM_W-1:0]    cand;
  logic [ppa_pkg::NUM_W-1:0]    fill_idx;
  logic [ppa_pkg::NUM_W-1:0]    res_num;
  ppa_pkg::outcome_t            res_code;

  logic                         ring_we;
  logic [ppa_pkg::NUM_W-1:0]    ring_waddr;
  logic [ppa_pkg::NUM_W-1:0]    ring_wdata;
  logic [ppa_pkg::NUM_W-1:0]    ring_rdata;
  logic                         stat_we;
  logic [ppa_pkg::NUM_W-1:0]    stat_waddr;
  logic [ppa_pkg::STATUS_W-1:0] stat_wdata;
  logic [ppa_pkg::NUM_W-1:0]    stat_raddr;
  logic [ppa_pkg::STATUS_W-1:0] stat_rdata;
  logic                         fill_in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_first <= '0;
      range_last  <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        ppa_pkg::CFG_RANGE_FIRST: range_first <= cfg_data;
        ppa_pkg::CFG_RANGE_LAST:  range_last  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
    end else begin
      if (ctl.init_load) begin
        head <= ppa_pkg::CNT_W'(range_first);
      end else if (ctl.head_inc) begin
        head <= head + ppa_pkg::CNT_W'(1);
      end
      if (ctl.init_load) begin
        tail <= ppa_pkg::CNT_W'(range_last) + ppa_pkg::CNT_W'(1);
      end else if (ctl.rel_write) begin
        tail <= tail + ppa_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch_in) begin
      num_in <= in_number;
    end
    if (ctl.latch_cand) begin
      cand <= ring_rdata;
    end
    if (ctl.fill_clear) begin
      fill_idx <= '0;
    end else if (ctl.fill_step) begin
      fill_idx <= fill_idx + ppa_pkg::NUM_W'(1);
    end
    if (ctl.res_load) begin
      res_code <= ctl.res_code;
      res_num  <= ctl.res_use_cand ? cand : '0;
    end
  end

  // output register: loads only when empty or being drained
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_number  <= res_num;
      out_outcome <= res_code;
    end
  end

  assign fill_in_range = (fill_idx >= range_first) && (fill_idx <= range_last);

  assign ring_we    = ctl.fill_step | ctl.rel_write;
  assign ring_waddr = ctl.fill_step ? fill_idx : tail[ppa_pkg::NUM_W-1:0];
  assign ring_wdata = ctl.fill_step ? fill_idx : num_in;

  assign stat_we = ctl.fill_step | ctl.take_write | ctl.rel_write;

  always_comb begin
    if (ctl.fill_step) begin
      stat_waddr = fill_idx;
      stat_wdata = fill_in_range ? ppa_pkg::STATUS_W'(fill_idx) : ppa_pkg::MARK_OUT_OF_RANGE;
    end else if (ctl.take_write) begin
      stat_waddr = cand;
      stat_wdata = ppa_pkg::MARK_TAKEN;
    end else begin
      stat_waddr = num_in;
      stat_wdata = tail;
    end
  end

  assign stat_raddr = ctl.stat_rd_rel ? num_in : ring_rdata;

  ppa_ram #(
    .WIDTH (ppa_pkg::NUM_W),
    .DEPTH (ppa_pkg::NUMBER_SPACE)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (ring_wdata),
    .raddr (head[ppa_pkg::NUM_W-1:0]),
    .rdata (ring_rdata)
  );

  ppa_ram #(
    .WIDTH (ppa_pkg::STATUS_W),
    .DEPTH (ppa_pkg::NUMBER_SPACE)
  ) u_status (
    .clk   (clk),
    .we    (stat_we),
    .waddr (stat_waddr),
    .wdata (stat_wdata),
    .raddr (stat_raddr),
    .rdata (stat_rdata)
  );

  assign sts.empty     = (tail <= head);
  assign sts.ring_bad  = (ring_rdata < range_first) || (ring_rdata > range_last);
  assign sts.skip      = (stat_rdata == ppa_pkg::MARK_TAKEN) || (stat_rdata != head);
  assign sts.range_bad = (range_first > range_last);
  assign sts.rel_ok    = (num_in != '0) && (num_in >= range_first) && (num_in <= range_last);
  assign sts.rel_taken = (stat_rdata == ppa_pkg::MARK_TAKEN);
  assign sts.fill_last = &fill_idx;
  assign sts.out_free  = !out_valid || out_ready;

endmodule

FILE: design/port_pool_allocator.sv
// ----------------------------------------------------------------------------
// port_pool_allocator
// Circular free-list allocator of numbers in [range_first, range_last].
// ----------------------------------------------------------------------------
// One command is worked at a time; the next is taken once the previous
// result sits in the output register, even if that result is not yet
// taken. A release of an ignored number skips the status read. An allocate
// ends on a hand-out, a corrupt ring entry or an empty pool, after skipping
// any stale or taken ring entries (each probe is a ring read followed by a
// status read, one read port per memory). Init sweeps both 1024-entry
// memories one entry a cycle, unless the range is refused. A stalled result
// transfer holds the block in its done state. Both memories hold garbage
// after reset, so issue init before anything else; until then only allocate
// (which reports an empty pool), a no-op or a release of zero is meaningful.
// Config registers are to be written only while the block is idle.
module port_pool_allocator (
  input  logic                          clk,
  input  logic                          rst,
  // configuration: index 0 range_first, index 1 range_last
  input  logic                          cfg_we,
  input  logic [ppa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ppa_pkg::NUM_W-1:0]     cfg_data,
  // command stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [ppa_pkg::TDATA_W-1:0]   s_axis_tdata,  // [9:0] number_in, [15:10] zero
  input  logic [ppa_pkg::CMD_W-1:0]     s_axis_tuser,  // [1:0] command
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [ppa_pkg::TDATA_W-1:0]   m_axis_tdata,  // [9:0] number_out, [15:10] zero
  output logic [ppa_pkg::RES_W-1:0]     m_axis_tuser   // [1:0] outcome
);

  ppa_pkg::ctl_t              ctl;
  ppa_pkg::sts_t              sts;
  logic [ppa_pkg::NUM_W-1:0]  out_number;
  ppa_pkg::outcome_t          out_outcome;

  ppa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_cmd   (ppa_pkg::cmd_t'(s_axis_tuser)),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .ctl      (ctl)
  );

  ppa_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_number   (s_axis_tdata[ppa_pkg::NUM_W-1:0]),
    .ctl         (ctl),
    .sts         (sts),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .out_number  (out_number),
    .out_outcome (out_outcome)
  );

  assign m_axis_tdata = ppa_pkg::TDATA_W'(out_number);
  assign m_axis_tuser = out_outcome;

endmodule

FILE: design/ppa_checker.sv
// ----------------------------------------------------------------------------
// ppa_checker
// Port-level checks on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "port_pool_allocator_assert.svh"

module ppa_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [ppa_pkg::TDATA_W-1:0] m_axis_tdata,
  input logic [ppa_pkg::RES_W-1:0]   m_axis_tuser
);

  // a stalled result holds
  `PPA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // only a successful allocate carries a number
  `PPA_ASSERT_SAME(a_fail_zero, m_axis_tvalid && (m_axis_tuser != ppa_pkg::OUT_OK), m_axis_tdata == '0)

  // one command in flight: no back-to-back transfers on the input
  `PPA_ASSERT_NEXT(a_one_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // a new result appears only when a command has just finished
  `PPA_ASSERT_SAME(a_res_busy, $rose(m_axis_tvalid), $past(!s_axis_tready))

endmodule

bind port_pool_allocator ppa_checker u_checker (.*);

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stream-level test of port_pool_allocator. A directed part covers init,
// allocate, release and no-op, bad ranges, an empty pool, corrupt ring entries
// and ignored releases. Random command mixes follow, with the number range
// changed between phases. A scoreboard keeps its own copy of the ring,
// the status table and both counters, and checks each result transfer.
// ----------------------------------------------------------------------------
module testbench;
  import ppa_pkg::*;

  typedef struct {
    logic [NUM_W-1:0] number;
    outcome_t         outcome;
  } alloc_result_t;

  class pool_scoreboard;
    logic [STATUS_W-1:0] slot_status [NUMBER_SPACE];
    logic [NUM_W-1:0]    free_ring [NUMBER_SPACE];
    logic [CNT_W-1:0]    head_cnt;
    logic [CNT_W-1:0]    tail_cnt;
    logic [NUM_W-1:0]    first_num;
    logic [NUM_W-1:0]    last_num;
    alloc_result_t       expected_q [$];
    logic [NUM_W-1:0]    taken_q [$];
    int                  errors;

    function new();
      for (int i = 0; i < NUMBER_SPACE; i++) begin
        slot_status[i] = '0;
        free_ring[i]   = '0;
      end
      head_cnt  = '0;
      tail_cnt  = '0;
      first_num = '0;
      last_num  = NUM_W'(NUMBER_SPACE - 1);
      errors    = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [NUM_W-1:0] val);
      if (idx == CFG_RANGE_FIRST) first_num = val;
      else last_num = val;
    endfunction

    function bit in_range(logic [NUM_W-1:0] n);
      return n >= first_num && n <= last_num;
    endfunction

    // predict the result of one accepted command and queue it
    function void note_command(cmd_t cmd, logic [NUM_W-1:0] num);
      alloc_result_t    res;
      logic [NUM_W-1:0] cand;
      bit               done;
      res.number  = '0;
      res.outcome = OUT_OK;
      case (cmd)
        CMD_INIT: begin
          if (first_num > last_num) begin
            res.outcome = OUT_BAD_RANGE;
          end else begin
            for (int i = 0; i < NUMBER_SPACE; i++) begin
              slot_status[i] = in_range(NUM_W'(i)) ? STATUS_W'(i) : MARK_OUT_OF_RANGE;
              free_ring[i]   = NUM_W'(i);
            end
            head_cnt = CNT_W'(first_num);
            tail_cnt = CNT_W'(last_num) + 1;
            taken_q.delete();
          end
        end
        CMD_ALLOC: begin
          done = 1'b0;
          while (!done) begin
            if (tail_cnt <= head_cnt) begin
              res.outcome = OUT_EMPTY;
              done = 1'b1;
            end else begin
              cand = free_ring[head_cnt[NUM_W-1:0]];
              if (!in_range(cand)) begin
                // corrupt entry: head stays put
                res.outcome = OUT_CORRUPT;
                done = 1'b1;
              end else if (slot_status[cand] == MARK_TAKEN ||
                           slot_status[cand] != head_cnt) begin
                head_cnt++;
              end else begin
                slot_status[cand] = MARK_TAKEN;
                head_cnt++;
                res.number = cand;
                taken_q.push_back(cand);
                done = 1'b1;
              end
            end
          end
        end
        CMD_RELEASE: begin
          if (num != 0 && in_range(num) && slot_status[num] == MARK_TAKEN) begin
            slot_status[num] = tail_cnt;
            free_ring[tail_cnt[NUM_W-1:0]] = num;
            tail_cnt++;
          end
        end
        default: ;
      endcase
      expected_q.push_back(res);
    endfunction

    function void check_result(logic [NUM_W-1:0] number, outcome_t outcome);
      alloc_result_t exp_res;
      if (expected_q.size() == 0) begin
        $error("unexpected result: number_out %0d, outcome %0d", number, outcome);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (number !== exp_res.number) begin
        $error("number_out: expected %0d, actual %0d", exp_res.number, number);
        errors++;
      end
      if (outcome !== exp_res.outcome) begin
        $error("outcome: expected %0d, actual %0d", exp_res.outcome, outcome);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [NUM_W-1:0]     cfg_data = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [TDATA_W-1:0]   s_axis_tdata = '0;  // [9:0] number_in, [15:10] zero
  logic [CMD_W-1:0]     s_axis_tuser = '0;  // [1:0] command
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]   m_axis_tdata;       // [9:0] number_out, [15:10] zero
  logic [RES_W-1:0]     m_axis_tuser;       // [1:0] outcome

  pool_scoreboard sb;
  int             send_gap_pct;
  int             recv_stall_pct;

  port_pool_allocator u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata[NUM_W-1:0], outcome_t'(m_axis_tuser));
    end
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_command(cmd_t cmd, logic [NUM_W-1:0] num);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(TDATA_W-NUM_W){1'b0}}, num};
    s_axis_tuser  <= cmd;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_command(cmd, num);
    @(negedge clk);
  endtask

  // drain every pending result, then write both range registers
  task automatic apply_range(logic [NUM_W-1:0] first, logic [NUM_W-1:0] last);
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_RANGE_FIRST;
    cfg_data  <= first;
    @(negedge clk);
    cfg_index <= CFG_RANGE_LAST;
    cfg_data  <= last;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(CFG_RANGE_FIRST, first);
    sb.set_reg(CFG_RANGE_LAST, last);
  endtask

  task automatic run_directed();
    // before any init only an empty allocate, a no-op and a zero release
    send_command(CMD_ALLOC, '0);
    send_command(CMD_NOP, 10'd1023);
    send_command(CMD_RELEASE, '0);
    apply_range(10'd9, 10'd3);
    send_command(CMD_INIT, '0);
    apply_range(10'd0, 10'd1023);
    send_command(CMD_INIT, 10'd1023);
    send_command(CMD_ALLOC, '0);
    send_command(CMD_ALLOC, '0);
    send_command(CMD_RELEASE, 10'd1);
    send_command(CMD_RELEASE, 10'd1);
    send_command(CMD_RELEASE, 10'd0);
    send_command(CMD_RELEASE, 10'd1023);
    send_command(CMD_ALLOC, '0);
    // narrow the range without init: the ring entry at the head is corrupt
    apply_range(10'd512, 10'd1023);
    send_command(CMD_ALLOC, '0);
    send_command(CMD_RELEASE, 10'd2);
    apply_range(10'd1023, 10'd1023);
    send_command(CMD_INIT, '0);
    send_command(CMD_ALLOC, '0);
    send_command(CMD_ALLOC, '0);
    send_command(CMD_RELEASE, 10'd1023);
    send_command(CMD_ALLOC, '0);
    send_command(CMD_RELEASE, 10'd682);
    apply_range(10'd0, 10'd0);
    send_command(CMD_INIT, '0);
    send_command(CMD_ALLOC, '0);
    send_command(CMD_RELEASE, 10'd0);
    send_command(CMD_ALLOC, '0);
  endtask

  task automatic pick_range();
    int               kind;
    logic [NUM_W-1:0] first;
    logic [NUM_W-1:0] last;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      first = NUM_W'($urandom_range(0, NUMBER_SPACE - 1));
      last  = NUM_W'((int'(first) + $urandom_range(0, 31) > NUMBER_SPACE - 1) ?
                     NUMBER_SPACE - 1 : int'(first) + $urandom_range(0, 31));
    end else if (kind < 70) begin
      first = '0;
      last  = NUM_W'(NUMBER_SPACE - 1);
    end else if (kind < 75) begin
      first = '0;
      last  = '0;
    end else if (kind < 80) begin
      first = NUM_W'(NUMBER_SPACE - 1);
      last  = NUM_W'(NUMBER_SPACE - 1);
    end else if (kind < 88) begin
      // first above last: init must refuse
      first = NUM_W'($urandom_range(1, NUMBER_SPACE - 1));
      last  = NUM_W'($urandom_range(0, int'(first) - 1));
    end else begin
      // move only the lower bound, leaving stale entries below it in the ring
      last  = sb.last_num;
      first = (sb.first_num <= sb.last_num) ?
              NUM_W'($urandom_range(sb.first_num, sb.last_num)) : sb.first_num;
    end
    apply_range(first, last);
    if ($urandom_range(0, 99) < 70) send_command(CMD_INIT, NUM_W'($urandom));
  endtask

  task automatic run_random(int count);
    int               sel;
    int               idx;
    logic [NUM_W-1:0] num;
    for (int k = 0; k < count; k++) begin
      if (k % 60 == 0) pick_range();
      sel = $urandom_range(0, 99);
      num = NUM_W'($urandom);
      if (sel < 4) begin
        send_command(CMD_INIT, num);
      end else if (sel < 45) begin
        send_command(CMD_ALLOC, num);
      end else if (sel < 80 && sb.taken_q.size() != 0) begin
        idx = $urandom_range(0, sb.taken_q.size() - 1);
        num = sb.taken_q[idx];
        sb.taken_q.delete(idx);
        send_command(CMD_RELEASE, num);
      end else if (sel < 92) begin
        // stray release: any number, or one inside the current range
        if ($urandom_range(0, 1) == 1 && sb.first_num <= sb.last_num)
          num = NUM_W'($urandom_range(sb.first_num, sb.last_num));
        send_command(CMD_RELEASE, num);
      end else begin
        send_command(CMD_NOP, num);
      end
    end
  endtask

  initial begin
    sb = new();
    send_gap_pct   = 27;
    recv_stall_pct = 49;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    run_directed();
    run_random(484);
    send_gap_pct   = 49;
    recv_stall_pct = 27;
    run_random(484);
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    run_random(484);
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
